// ----- design/ddwcw_pkg.sv -----
// shared types and constants of the wheel command watchdog block
package ddwcw_pkg;

  // input beat kinds carried on tuser
  localparam logic [1:0] FUNC_CMD   = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_BRAKE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_TIMEOUT  = 3'd0;
  localparam logic [2:0] REG_MAX_SPD  = 3'd1;
  localparam logic [2:0] REG_HALF_SEP = 3'd2;
  localparam logic [2:0] REG_INV_RAD  = 3'd3;
  localparam logic [2:0] REG_TICK_PER = 3'd4;
  localparam logic [2:0] REG_PWM_TOP  = 3'd5;

  // configuration reset values
  localparam logic [15:0] TIMEOUT_RST  = 16'd300;
  localparam logic [14:0] MAX_SPD_RST  = 15'd17408;
  localparam logic [15:0] HALF_SEP_RST = 16'd6554;
  localparam logic [15:0] INV_RAD_RST  = 16'd5689;
  localparam logic [15:0] TICK_PER_RST = 16'd655;
  localparam logic [15:0] PWM_TOP_RST  = 16'd999;

  // serial unit geometry
  localparam int ACC_W     = 52;
  localparam int CNT_W     = 5;
  localparam logic [CNT_W-1:0] MUL_LAST = 5'd15;
  localparam logic [CNT_W-1:0] DIV_LAST = 5'd30;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TURN,
    ST_LMUL,
    ST_RMUL,
    ST_LANG,
    ST_RANG,
    ST_DMUL,
    ST_DDIV,
    ST_DONE
  } state_t;

endpackage

// ----- design/diff_drive_wheel_command_watchdog_core.sv -----
// top level: differential drive wheel speeds, watchdog, angle and pwm update
// A command runs three 16-step bit-serial multiplies; a tick runs two angle multiplies,
// then, unless tripped or the clamp is zero, one duty multiply and a 31-step restoring
// divide; a brake or unused kind goes straight to the output.
// One item is taken at a time, as all share the bit-serial multiplier and divider.
// Reset (rst, synchronous): registers to defaults, speeds and angles zero, tripped.
module diff_drive_wheel_command_watchdog_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // linear_velocity, angular_velocity, now_ms
  input  logic [1:0]   s_tuser,   // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata    // left_speed, right_speed, left_angle, right_angle,
                                  // pwm_level, tripped, zero pad
);

  localparam int AW = ddwcw_pkg::ACC_W;

  // configuration registers
  logic [15:0] watchdog_timeout_ms;
  logic [14:0] max_wheel_speed;
  logic [15:0] half_separation;
  logic [15:0] inverse_radius;
  logic [15:0] tick_period;
  logic [15:0] pwm_top;

  // architectural state
  logic signed [15:0] sp_left;
  logic signed [15:0] sp_right;
  logic [31:0]        last_cmd_time;
  logic               wd_flag;
  logic [31:0]        angle_left;
  logic [31:0]        angle_right;
  logic [15:0]        duty_level;

  // sequencer and serial datapath
  ddwcw_pkg::state_t state, state_next;
  logic [ddwcw_pkg::CNT_W-1:0] cnt;
  logic signed [AW-1:0] mcand;
  logic [15:0]          mplier;
  logic signed [AW-1:0] acc;
  logic signed [33:0]   body_r;
  logic signed [15:0]   cmd_lin;
  logic [31:0]          cmd_time;
  logic [14:0]          rem;
  logic [30:0]          dvd;

  logic in_beat;
  logic out_load;

  // input fields
  logic [1:0]         in_func;
  logic signed [15:0] in_lin;
  logic signed [15:0] in_ang;
  logic [31:0]        in_now;

  assign in_func = s_tuser;
  assign in_lin  = signed'(s_tdata[15:0]);
  assign in_ang  = signed'(s_tdata[31:16]);
  assign in_now  = s_tdata[63:32];
  assign in_beat = s_tvalid && s_tready;

  // one shift-add step of the serial multiplier
  logic signed [AW-1:0] acc_sum;
  assign acc_sum = acc + (mplier[0] ? mcand : '0);

  // body velocities from the finished turn product
  logic signed [33:0] lin_sh;
  logic signed [33:0] turn;
  logic signed [33:0] body_l_new;
  logic signed [33:0] body_r_new;
  assign lin_sh     = signed'({{4{cmd_lin[15]}}, cmd_lin, 14'b0});
  assign turn       = signed'(acc_sum[33:0]);
  assign body_l_new = lin_sh - turn;
  assign body_r_new = lin_sh + turn;

  // wheel speed rounding to nearest, ties up, and clamping
  logic signed [AW-1:0] spd_sum;
  logic signed [27:0]   spd_s;
  logic signed [27:0]   spd_lim;
  logic signed [15:0]   spd_clamped;
  assign spd_sum = acc_sum + signed'(AW'(64'd1 << 23));
  assign spd_s   = signed'(spd_sum[51:24]);
  assign spd_lim = signed'({13'b0, max_wheel_speed});
  always_comb begin
    if (spd_s > spd_lim) begin
      spd_clamped = spd_lim[15:0];
    end else if (spd_s < -spd_lim) begin
      spd_clamped = 16'(-spd_lim);
    end else begin
      spd_clamped = spd_s[15:0];
    end
  end

  // angle increment, rounded to nearest, ties up
  logic signed [AW-1:0] ang_sum;
  logic [31:0]          ang_d;
  assign ang_sum = acc_sum + signed'(AW'(64'd512));
  assign ang_d   = ang_sum[41:10];

  // watchdog check on a tick
  logic [31:0] elapsed;
  logic        trip_now;
  logic        flag_new;
  assign elapsed  = in_now - last_cmd_time;
  assign trip_now = !wd_flag && (elapsed >= {16'b0, watchdog_timeout_ms});
  assign flag_new = wd_flag || trip_now;

  // left setpoint magnitude for the duty level
  logic [15:0] sp_abs;
  logic [14:0] mag;
  assign sp_abs = sp_left[15] ? 16'(-sp_left) : sp_left;
  assign mag    = sp_abs[14:0];

  // restoring divide step
  logic [15:0] rem_sh;
  logic        q_bit;
  logic [15:0] rem_sub;
  logic [30:0] quot;
  assign rem_sh  = {rem, dvd[30]};
  assign q_bit   = rem_sh >= {1'b0, max_wheel_speed};
  assign rem_sub = rem_sh - {1'b0, max_wheel_speed};
  assign quot    = {dvd[29:0], q_bit};

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddwcw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ddwcw_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (in_func)
            ddwcw_pkg::FUNC_CMD:  state_next = ddwcw_pkg::ST_TURN;
            ddwcw_pkg::FUNC_TICK: state_next = ddwcw_pkg::ST_LANG;
            default:              state_next = ddwcw_pkg::ST_DONE;
          endcase
        end
      end
      ddwcw_pkg::ST_TURN: begin
        if (cnt == ddwcw_pkg::MUL_LAST) state_next = ddwcw_pkg::ST_LMUL;
      end
      ddwcw_pkg::ST_LMUL: begin
        if (cnt == ddwcw_pkg::MUL_LAST) state_next = ddwcw_pkg::ST_RMUL;
      end
      ddwcw_pkg::ST_RMUL: begin
        if (cnt == ddwcw_pkg::MUL_LAST) state_next = ddwcw_pkg::ST_DONE;
      end
      ddwcw_pkg::ST_LANG: begin
        if (cnt == ddwcw_pkg::MUL_LAST) state_next = ddwcw_pkg::ST_RANG;
      end
      ddwcw_pkg::ST_RANG: begin
        if (cnt == ddwcw_pkg::MUL_LAST) begin
          if (wd_flag || max_wheel_speed == 15'd0) begin
            state_next = ddwcw_pkg::ST_DONE;
          end else begin
            state_next = ddwcw_pkg::ST_DMUL;
          end
        end
      end
      ddwcw_pkg::ST_DMUL: begin
        if (cnt == ddwcw_pkg::MUL_LAST) state_next = ddwcw_pkg::ST_DDIV;
      end
      ddwcw_pkg::ST_DDIV: begin
        if (cnt == ddwcw_pkg::DIV_LAST) state_next = ddwcw_pkg::ST_DONE;
      end
      ddwcw_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ddwcw_pkg::ST_IDLE;
        end
      end
      default: state_next = ddwcw_pkg::ST_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      watchdog_timeout_ms <= ddwcw_pkg::TIMEOUT_RST;
      max_wheel_speed     <= ddwcw_pkg::MAX_SPD_RST;
      half_separation     <= ddwcw_pkg::HALF_SEP_RST;
      inverse_radius      <= ddwcw_pkg::INV_RAD_RST;
      tick_period         <= ddwcw_pkg::TICK_PER_RST;
      pwm_top             <= ddwcw_pkg::PWM_TOP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ddwcw_pkg::REG_TIMEOUT:  watchdog_timeout_ms <= cfg_data;
        ddwcw_pkg::REG_MAX_SPD:  max_wheel_speed     <= cfg_data[14:0];
        ddwcw_pkg::REG_HALF_SEP: half_separation     <= cfg_data;
        ddwcw_pkg::REG_INV_RAD:  inverse_radius      <= cfg_data;
        ddwcw_pkg::REG_TICK_PER: tick_period         <= cfg_data;
        ddwcw_pkg::REG_PWM_TOP:  pwm_top             <= cfg_data;
        default: ;
      endcase
    end
  end

  // step counter of the serial units
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ddwcw_pkg::ST_IDLE || state == ddwcw_pkg::ST_DONE) begin
      cnt <= '0;
    end else if (state == ddwcw_pkg::ST_DDIV) begin
      cnt <= (cnt == ddwcw_pkg::DIV_LAST) ? '0 : cnt + 1'b1;
    end else begin
      cnt <= (cnt == ddwcw_pkg::MUL_LAST) ? '0 : cnt + 1'b1;
    end
  end

  // architectural state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      sp_left       <= '0;
      sp_right      <= '0;
      last_cmd_time <= '0;
      wd_flag       <= 1'b1;
      angle_left    <= '0;
      angle_right   <= '0;
      duty_level    <= '0;
    end else begin
      case (state)
        ddwcw_pkg::ST_IDLE: begin
          if (in_beat) begin
            if (in_func == ddwcw_pkg::FUNC_TICK && trip_now) begin
              wd_flag    <= 1'b1;
              sp_left    <= '0;
              sp_right   <= '0;
              duty_level <= '0;
            end else if (in_func == ddwcw_pkg::FUNC_BRAKE) begin
              wd_flag    <= 1'b1;
              sp_left    <= '0;
              sp_right   <= '0;
              duty_level <= '0;
            end
          end
        end
        ddwcw_pkg::ST_LMUL: begin
          if (cnt == ddwcw_pkg::MUL_LAST) sp_left <= spd_clamped;
        end
        ddwcw_pkg::ST_RMUL: begin
          if (cnt == ddwcw_pkg::MUL_LAST) begin
            sp_right      <= spd_clamped;
            last_cmd_time <= cmd_time;
            wd_flag       <= 1'b0;
          end
        end
        ddwcw_pkg::ST_LANG: begin
          if (cnt == ddwcw_pkg::MUL_LAST) angle_left <= angle_left + ang_d;
        end
        ddwcw_pkg::ST_RANG: begin
          if (cnt == ddwcw_pkg::MUL_LAST) begin
            angle_right <= angle_right + ang_d;
            if (wd_flag) begin
              duty_level <= '0;
            end else if (max_wheel_speed == 15'd0) begin
              duty_level <= (mag != 15'd0) ? pwm_top : 16'd0;
            end
          end
        end
        ddwcw_pkg::ST_DDIV: begin
          if (cnt == ddwcw_pkg::DIV_LAST) begin
            duty_level <= (quot > {15'b0, pwm_top}) ? pwm_top : quot[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  // serial multiplier and divider operands
  always_ff @(posedge clk) begin
    case (state)
      ddwcw_pkg::ST_IDLE: begin
        acc      <= '0;
        cmd_lin  <= in_lin;
        cmd_time <= in_now;
        if (in_func == ddwcw_pkg::FUNC_CMD) begin
          mcand  <= signed'({{(AW-16){in_ang[15]}}, in_ang});
          mplier <= half_separation;
        end else begin
          mcand  <= flag_new ? '0 : signed'({{(AW-16){sp_left[15]}}, sp_left});
          mplier <= tick_period;
        end
      end
      ddwcw_pkg::ST_TURN: begin
        if (cnt == ddwcw_pkg::MUL_LAST) begin
          acc    <= '0;
          mcand  <= signed'({{(AW-34){body_l_new[33]}}, body_l_new});
          mplier <= inverse_radius;
          body_r <= body_r_new;
        end else begin
          acc    <= acc_sum;
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
        end
      end
      ddwcw_pkg::ST_LMUL: begin
        if (cnt == ddwcw_pkg::MUL_LAST) begin
          acc    <= '0;
          mcand  <= signed'({{(AW-34){body_r[33]}}, body_r});
          mplier <= inverse_radius;
        end else begin
          acc    <= acc_sum;
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
        end
      end
      ddwcw_pkg::ST_LANG: begin
        if (cnt == ddwcw_pkg::MUL_LAST) begin
          acc    <= '0;
          mcand  <= wd_flag ? '0 : signed'({{(AW-16){sp_right[15]}}, sp_right});
          mplier <= tick_period;
        end else begin
          acc    <= acc_sum;
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
        end
      end
      ddwcw_pkg::ST_RANG: begin
        if (cnt == ddwcw_pkg::MUL_LAST) begin
          acc    <= '0;
          mcand  <= signed'({{(AW-15){1'b0}}, mag});
          mplier <= pwm_top;
        end else begin
          acc    <= acc_sum;
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
        end
      end
      ddwcw_pkg::ST_DMUL: begin
        if (cnt == ddwcw_pkg::MUL_LAST) begin
          dvd <= acc_sum[30:0];
          rem <= '0;
        end else begin
          acc    <= acc_sum;
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
        end
      end
      ddwcw_pkg::ST_DDIV: begin
        rem <= q_bit ? rem_sub[14:0] : rem_sh[14:0];
        dvd <= quot;
      end
      default: begin
        acc    <= acc_sum;
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata[15:0]    <= wd_flag ? 16'd0 : sp_left;
      m_tdata[31:16]   <= wd_flag ? 16'd0 : sp_right;
      m_tdata[63:32]   <= angle_left;
      m_tdata[95:64]   <= angle_right;
      m_tdata[111:96]  <= duty_level;
      m_tdata[112]     <= wd_flag;
      m_tdata[119:113] <= '0;
    end
  end

endmodule
